FILE: src/mlbpc_pkg.sv
// Package for the multi-LED blink and PWM controller.
// Holds the operation, mode and state codes and the fixed reset constants.
// No dependencies.
package mlbpc_pkg;

    // Width of the PWM period register.
    localparam int PERIOD_W = 8;

    // Reset value of the PWM period and of every LED's rate and counter.
    localparam int RESET_PERIOD = 20;

    // Configuration register indexes.
    localparam logic CFG_ACTIVE_LOW = 1'b0;
    localparam logic CFG_PWM_PERIOD = 1'b1;

    typedef enum logic [2:0] {
        OP_TICK   = 3'd0,
        OP_ON     = 3'd1,
        OP_OFF    = 3'd2,
        OP_TOGGLE = 3'd3,
        OP_PWM    = 3'd4,
        OP_BLINK  = 3'd5
    } t_op;

    typedef enum logic [1:0] {
        MODE_STEADY = 2'd0,
        MODE_PWM    = 2'd1,
        MODE_BLINK  = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_OUT
    } t_state;

endpackage

FILE: src/mlbpc_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// No dependencies.
module mlbpc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/multi_led_blink_pwm_controller.sv
// Multi-LED blink and PWM controller, top level.
// Depends on mlbpc_pkg and mlbpc_ram.
//
// Flow: a tick transaction updates every LED's entry in turn, from LED 0 up, and a command
// transaction updates at most one entry; the result then goes to the output register, and
// a new transaction stalls until then. The per-LED state RAM is read and written back for
// one LED per cycle. Reset is synchronous and active low; it clears the pins and the per-LED
// valid bits and resets the configuration, so every LED reads its reset state until written.
module multi_led_blink_pwm_controller
    import mlbpc_pkg::*;
#(
    parameter int NUM_LEDS    = 12,
    parameter int COUNT_WIDTH = 16,
    localparam int IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1,
    localparam int CFG_W = (NUM_LEDS > PERIOD_W) ? NUM_LEDS : PERIOD_W
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // Configuration write port.
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_index,
    input  logic [CFG_W-1:0]       i_cfg_data,
    // Input channel.
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [2:0]             i_operation,
    input  logic [IDX_W-1:0]       i_led_index,
    input  logic [COUNT_WIDTH-1:0] i_rate,
    // Output channel.
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [NUM_LEDS-1:0]    o_pin_levels
);

    localparam int CW     = COUNT_WIDTH;
    // State RAM word: {mode, phase, rate, counter}.
    localparam int WORD_W = 2 * CW + 3;
    localparam logic [IDX_W-1:0] LAST_LED = IDX_W'(NUM_LEDS - 1);
    localparam logic [WORD_W-1:0] RESET_WORD =
        {MODE_STEADY, 1'b1, CW'(RESET_PERIOD), CW'(RESET_PERIOD)};

    t_state                r_state, n_state;
    logic [IDX_W-1:0]      r_led, n_led;
    t_op                   r_op;
    logic [CW-1:0]         r_rate;
    logic                  r_cmd_ok;
    logic [NUM_LEDS-1:0]   r_pin, n_pin;
    logic [NUM_LEDS-1:0]   r_active_low;
    logic [PERIOD_W-1:0]   r_pwm_period;
    logic [NUM_LEDS-1:0]   r_entry_valid;
    logic                  r_rd_valid;
    logic                  r_out_valid;
    logic [NUM_LEDS-1:0]   r_out_pins;

    logic                  in_accept;
    logic                  in_cmd_ok;
    logic                  out_load;

    logic                  ram_we;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [WORD_W-1:0]     ram_wdata;
    logic [WORD_W-1:0]     ram_rdata;

    // Fields of the entry being processed and of its updated copy.
    logic [WORD_W-1:0]     cur_word;
    logic [1:0]            cur_mode, new_mode;
    logic                  cur_phase, new_phase;
    logic [CW-1:0]         cur_rate, new_rate;
    logic [CW-1:0]         cur_cnt, new_cnt;
    logic [CW-1:0]         cnt_dec;
    logic [CW-1:0]         period_ext;
    logic                  led_al;
    logic                  pin_bit;

    // An input transaction is taken only between items; the result register on the
    // output side lets the next item enter while the last result is still waiting.
    assign in_accept  = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // A command is applied only for a known operation and an LED that exists.
    always_comb begin
        in_cmd_ok = 1'b0;
        if ({1'b0, i_led_index} < (IDX_W + 1)'(NUM_LEDS)) begin
            case (t_op'(i_operation))
                OP_ON, OP_OFF, OP_TOGGLE, OP_PWM, OP_BLINK: in_cmd_ok = 1'b1;
                default:                                    in_cmd_ok = 1'b0;
            endcase
        end
    end

    mlbpc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_LEDS)
    ) u_state_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_led),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // An entry that has never been written reads as its reset state.
    assign cur_word   = r_rd_valid ? ram_rdata : RESET_WORD;
    assign cur_mode   = cur_word[WORD_W-1 -: 2];
    assign cur_phase  = cur_word[2*CW];
    assign cur_rate   = cur_word[2*CW-1 -: CW];
    assign cur_cnt    = cur_word[CW-1:0];
    assign cnt_dec    = cur_cnt - CW'(1);
    assign period_ext = CW'(r_pwm_period);
    assign led_al     = r_active_low[r_led];
    assign ram_wdata  = {new_mode, new_phase, new_rate, new_cnt};

    // Sequencer: the read for the first entry is issued at acceptance; each walk cycle
    // then updates the entry whose data has just arrived and, during a tick, issues the
    // read of the next LED. Reads and writes never touch the same entry in one cycle.
    always_comb begin
        n_state   = r_state;
        n_led     = r_led;
        n_pin     = r_pin;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = r_led;
        new_mode  = cur_mode;
        new_phase = cur_phase;
        new_rate  = cur_rate;
        new_cnt   = cur_cnt;
        pin_bit   = r_pin[r_led];
        out_load  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    ram_re = 1'b1;
                    if ((t_op'(i_operation) == OP_TICK) || !in_cmd_ok) begin
                        ram_raddr = '0;
                    end else begin
                        ram_raddr = i_led_index;
                    end
                    n_led   = ram_raddr;
                    n_state = S_WALK;
                end
            end

            S_WALK: begin
                if (r_op == OP_TICK) begin
                    ram_we = 1'b1;
                    case (t_mode'(cur_mode))
                        MODE_PWM: begin
                            if (cur_rate == '0) begin
                                pin_bit = led_al;
                            end else if (cur_rate >= period_ext) begin
                                pin_bit = ~led_al;
                            end else begin
                                new_cnt = cnt_dec;
                                if (cnt_dec == '0) begin
                                    if (cur_phase) begin
                                        pin_bit   = led_al;
                                        new_cnt   = period_ext - cur_rate;
                                        new_phase = 1'b0;
                                    end else begin
                                        pin_bit   = ~led_al;
                                        new_cnt   = cur_rate;
                                        new_phase = 1'b1;
                                    end
                                end
                            end
                        end
                        MODE_BLINK: begin
                            new_cnt = cnt_dec;
                            if (cnt_dec == '0) begin
                                pin_bit = ~r_pin[r_led];
                                new_cnt = cur_rate;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (r_led != LAST_LED) begin
                        ram_re    = 1'b1;
                        ram_raddr = r_led + IDX_W'(1);
                        n_led     = ram_raddr;
                    end else begin
                        n_state = S_OUT;
                    end
                end else begin
                    ram_we = r_cmd_ok;
                    case (r_op)
                        OP_ON: begin
                            pin_bit  = ~led_al;
                            new_mode = MODE_STEADY;
                        end
                        OP_OFF: begin
                            pin_bit  = led_al;
                            new_mode = MODE_STEADY;
                        end
                        OP_TOGGLE: begin
                            pin_bit = ~r_pin[r_led];
                        end
                        OP_PWM: begin
                            new_mode  = MODE_PWM;
                            new_rate  = r_rate;
                            new_cnt   = r_rate;
                            new_phase = 1'b1;
                        end
                        OP_BLINK: begin
                            new_mode = MODE_BLINK;
                            new_rate = r_rate;
                            new_cnt  = r_rate;
                        end
                        default: begin
                        end
                    endcase
                    if (!r_cmd_ok) begin
                        pin_bit = r_pin[r_led];
                    end
                    n_state = S_OUT;
                end
                n_pin[r_led] = pin_bit;
            end

            S_OUT: begin
                // Hand the pin vector to the result register once it is free.
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_led         <= '0;
            r_pin         <= '0;
            r_active_low  <= '0;
            r_pwm_period  <= PERIOD_W'(RESET_PERIOD);
            r_entry_valid <= '0;
            r_rd_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_led   <= n_led;
            r_pin   <= n_pin;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_ACTIVE_LOW) begin
                    r_active_low <= i_cfg_data[NUM_LEDS-1:0];
                end else begin
                    r_pwm_period <= i_cfg_data[PERIOD_W-1:0];
                end
            end
            if (ram_we) begin
                r_entry_valid[r_led] <= 1'b1;
            end
            if (ram_re) begin
                r_rd_valid <= r_entry_valid[ram_raddr];
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Item and result payload registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_op     <= t_op'(i_operation);
            r_rate   <= i_rate;
            r_cmd_ok <= in_cmd_ok;
        end
        if (out_load) begin
            r_out_pins <= r_pin;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pin_levels = r_out_pins;

    // A command visits exactly one entry before its result is queued.
    a_cmd_one_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) && (r_op != OP_TICK) |=> (r_state == S_OUT))
        else $error("command took more than one walk cycle");

    // The state RAM is written only while an item is being walked.
    a_write_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_WALK))
        else $error("state RAM written outside the walk");

    // The walk never addresses an LED that does not exist.
    a_led_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> ({1'b0, r_led} < (IDX_W + 1)'(NUM_LEDS)))
        else $error("walk index out of range");

    // Reset leaves every entry reading as its reset state.
    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_entry_valid == '0))
        else $error("entry valid bits not cleared by reset");

    // A result is queued only after the item's last entry has been written back.
    a_out_after_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |-> $past(r_state == S_WALK) || $past(r_state == S_OUT))
        else $error("result queued without a walk");

endmodule
